[rtl/core/cpsl_pkg.sv]
// Shared constants and controller/datapath command and status types.
package cpsl_pkg;

  localparam int MAX_TOTAL_DEF = 512;
  localparam int SYM_W         = 8;
  localparam int BEST_W        = 10;
  localparam int TDATA_IN_W    = 8;
  localparam int TDATA_OUT_W   = 16;

  typedef struct packed {
    logic load;    // store an accepted request
    logic init;    // set up the first diagonal
    logic calc;    // evaluate and write one cell, then advance
    logic finish;  // publish the result and clear the sequence
  } cpsl_cmd_t;

  typedef struct packed {
    logic short_seq;  // fewer than two stored symbols
    logic cell_last;  // current cell closes its diagonal
    logic diag_last;  // current diagonal spans the whole sequence
  } cpsl_status_t;

endpackage

[rtl/core/cpsl_ctrl.sv]
// Controller: sequences load, diagonal sweep and result hand-off.
module cpsl_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_last,
  output logic                  in_ready,
  input  logic                  out_busy,
  input  cpsl_pkg::cpsl_status_t status,
  output cpsl_pkg::cpsl_cmd_t    cmd
);
  import cpsl_pkg::*;

  typedef enum logic [2:0] {LOAD, START, CELL_RD, CELL_CALC, FINISH} state_t;
  state_t state;

  assign in_ready = (state == LOAD);

  always_comb begin
    cmd = '0;
    unique case (state)
      LOAD:      cmd.load   = in_valid;
      START:     cmd.init   = 1'b1;
      CELL_RD:   ;
      CELL_CALC: cmd.calc   = 1'b1;
      FINISH:    cmd.finish = !out_busy;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= LOAD;
    end else begin
      unique case (state)
        LOAD:      if (in_valid && in_last) state <= START;
        START:     state <= status.short_seq ? FINISH : CELL_RD;
        CELL_RD:   state <= CELL_CALC;
        CELL_CALC: begin
          if (status.cell_last && status.diag_last) state <= FINISH;
          else state <= CELL_RD;
        end
        FINISH:    if (!out_busy) state <= LOAD;
        default:   state <= LOAD;
      endcase
    end
  end
endmodule

[rtl/core/cpsl_datapath.sv]
// Datapath: symbol store, three rotating diagonal banks, cell update, result.
module cpsl_datapath #(
  parameter int MAX_TOTAL = cpsl_pkg::MAX_TOTAL_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [cpsl_pkg::SYM_W-1:0]        in_symbol,
  input  logic                              in_second,
  input  cpsl_pkg::cpsl_cmd_t               cmd,
  output cpsl_pkg::cpsl_status_t            status,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [cpsl_pkg::BEST_W-1:0]       out_best,
  output logic                              out_overflow
);
  import cpsl_pkg::*;

  localparam int AW = $clog2(MAX_TOTAL);
  localparam int CW = AW + 1;
  localparam int DW = $clog2(MAX_TOTAL + 1);

  logic [SYM_W-1:0] sym_mem [MAX_TOTAL];
  logic [DW-1:0]    diag_mem [3][MAX_TOTAL];

  logic [CW-1:0] count, first_len, len;
  logic [AW-1:0] idx;
  logic [1:0]    sel;
  logic [DW-1:0] best;
  logic          ovf;

  logic [SYM_W-1:0] sym_i_q, sym_j_q;
  logic [DW-1:0]    lo_q [3];
  logic [DW-1:0]    hi_q [3];

  logic [CW-1:0] j_wide;
  logic [AW-1:0] j_addr, idx_p1;
  logic [1:0]    sel_p, sel_p2;
  logic [DW-1:0] inner, va, vb, v;
  logic          eq, spans;

  assign j_wide = {1'b0, idx} + len - CW'(1);
  assign j_addr = j_wide[AW-1:0];
  assign idx_p1 = idx + AW'(1);
  assign sel_p  = (sel == 2'd0) ? 2'd2 : sel - 2'd1;
  assign sel_p2 = (sel == 2'd2) ? 2'd0 : sel + 2'd1;

  assign status.short_seq = (count < CW'(2));
  assign status.cell_last = ({1'b0, idx} == count - len);
  assign status.diag_last = (len == count);

  always_comb begin
    eq    = (sym_i_q == sym_j_q);
    // The length-0 and length-1 diagonals are constant and never stored.
    if (len == CW'(2)) begin
      inner = '0;
      va    = DW'(1);
      vb    = DW'(1);
    end else begin
      inner = (len == CW'(3)) ? DW'(1) : hi_q[sel_p2];
      va    = hi_q[sel_p];
      vb    = lo_q[sel_p];
    end
    v     = eq ? inner + DW'(2) : ((va > vb) ? va : vb);
    spans = eq && ({1'b0, idx} < first_len) && (j_wide >= first_len);
  end

  // Memories: registered reads every cycle, writes on load and cell update.
  always_ff @(posedge clk) begin
    sym_i_q <= sym_mem[idx];
    sym_j_q <= sym_mem[j_addr];
    for (int b = 0; b < 3; b++) begin
      lo_q[b] <= diag_mem[b][idx];
      hi_q[b] <= diag_mem[b][idx_p1];
    end
    if (cmd.load && count < CW'(MAX_TOTAL)) sym_mem[count[AW-1:0]] <= in_symbol;
    if (cmd.calc) diag_mem[sel][idx] <= v;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      first_len <= '0;
      best      <= '0;
      ovf       <= 1'b0;
      len       <= '0;
      idx       <= '0;
      sel       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.load) begin
        if (count < CW'(MAX_TOTAL)) begin
          if (!in_second && first_len == count) first_len <= first_len + CW'(1);
          count <= count + CW'(1);
        end else begin
          ovf <= 1'b1;
        end
      end
      if (cmd.init) begin
        len <= CW'(2);
        idx <= '0;
        sel <= 2'd2;
      end
      if (cmd.calc) begin
        if (spans && v > best) best <= v;
        if (status.cell_last) begin
          len <= len + CW'(1);
          idx <= '0;
          sel <= sel_p2;
        end else begin
          idx <= idx + AW'(1);
        end
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
        count     <= '0;
        first_len <= '0;
        best      <= '0;
        ovf       <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_best     <= BEST_W'(best);
      out_overflow <= ovf;
    end
  end
endmodule

[rtl/core/cross_palindrome_subseq_length.sv]
// Top level: cross-word longest palindromic subsequence length.
//
// Input stream: one symbol per request, tuser marks a second-word symbol,
// tlast closes the pair of words and starts the computation. Symbols load
// at one per cycle; symbols past MAX_TOTAL are dropped and flagged.
// After the last request the block sweeps the interval table one diagonal
// after another, one cell at a time: a read state for the registered
// memory reads, then an update state for the cell update. No input is
// taken during the sweep. The sweep is bound by the single cell unit.
// Output stream: one request per sequence carrying the best spanning
// length (0 if none) and the overflow flag. The result sits in an output
// register; the block goes back to loading while it waits, and only a
// second result waits for the receiver to drain the first.
// Reset clears counters and control; stores need no clearing since every
// entry is written before it is read.
module cross_palindrome_subseq_length #(
  parameter int MAX_TOTAL = cpsl_pkg::MAX_TOTAL_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [cpsl_pkg::TDATA_IN_W-1:0]     s_axis_tdata,  // [7:0] symbol
  input  logic                                s_axis_tuser,  // [0] from_second
  input  logic                                s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [cpsl_pkg::TDATA_OUT_W-1:0]    m_axis_tdata   // [9:0] best_length,
                                                             // [10] overflow
);
  import cpsl_pkg::*;

  cpsl_cmd_t    cmd;
  cpsl_status_t status;
  logic [BEST_W-1:0] best;
  logic              ovf;

  cpsl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_last  (s_axis_tlast),
    .in_ready (s_axis_tready),
    .out_busy (m_axis_tvalid && !m_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  cpsl_datapath #(.MAX_TOTAL(MAX_TOTAL)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .in_symbol    (s_axis_tdata[SYM_W-1:0]),
    .in_second    (s_axis_tuser),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_best     (best),
    .out_overflow (ovf)
  );

  assign m_axis_tdata = {{(TDATA_OUT_W - BEST_W - 1){1'b0}}, ovf, best};
endmodule
